### rtl/swft_pkg.sv
// ----------------------------------------------------------------------------
// swft_pkg
// Shared types, widths and helpers for the swing-foot trajectory core.
// ----------------------------------------------------------------------------
`default_nettype none

package swft_pkg;

  localparam int unsigned NAX     = 3;   // x, y, z lanes
  localparam int unsigned AX_Z    = 2;   // lane that uses the apex height
  localparam int unsigned POS_W   = 21;  // Q4.16 position
  localparam int unsigned VEL_W   = 24;  // Q7.16 velocity
  localparam int unsigned PHASE_W = 17;  // Q1.16 phase
  localparam int unsigned SLOPE_W = 23;  // Q7.16 slope
  localparam int unsigned CFG_W   = 23;  // widest register
  localparam int unsigned CIDX_W  = 3;

  // Horner accumulator widths (bounded by the coefficient magnitudes)
  localparam int unsigned HW = 32;  // position polynomial
  localparam int unsigned GW = 34;  // velocity polynomial

  localparam logic [SLOPE_W-1:0] SLOPE_RST = 23'd131072;  // 2.0

  typedef enum logic [CIDX_W-1:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_START_Z     = 3'd2,
    REG_FINAL_X     = 3'd3,
    REG_FINAL_Y     = 3'd4,
    REG_FINAL_Z     = 3'd5,
    REG_APEX_HEIGHT = 3'd6,
    REG_PHASE_SLOPE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [HW-1:0] h6;
    logic signed [HW-1:0] h5;
    logic signed [HW-1:0] h4;
    logic signed [HW-1:0] h3;
    logic signed [GW-1:0] g6;
    logic signed [GW-1:0] g5;
    logic signed [GW-1:0] g4;
    logic signed [GW-1:0] g3;
  } coef_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [HW:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[HW:POS_W-1];
    hi_zeros = ~|v[HW:POS_W-1];
    if (hi_ones || hi_zeros) begin
      return v[POS_W-1:0];
    end else if (v[HW]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [GW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[GW-1:VEL_W-1];
    hi_zeros = ~|v[GW-1:VEL_W-1];
    if (hi_ones || hi_zeros) begin
      return v[VEL_W-1:0];
    end else if (v[GW-1]) begin
      return {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VEL_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/swing_foot_polynomial_trajectory_core.sv
// ----------------------------------------------------------------------------
// swing_foot_polynomial_trajectory_core
// Sixth-order swing-foot trajectory: maps gait phase to trajectory time t and
// returns foot position and velocity per axis, saturated.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+------------------------------
//   cfg     | in  | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//   in      | in  | in_valid_i / in_stall_o   | phase_i
//   out     | out | out_valid_o / out_stall_i | pos_{x,y,z}_o, vel_{x,y,z}_o
//
// One transfer per cycle sustained while the output is not stalled.
// Latency is set by the six Horner steps, each a multiply stage followed by
// a round-and-add stage, plus phase-map, t and output saturation stages.
// Reset empties the pipeline and restores register defaults (slope 2.0).
// An output stall holds the last stage; bubbles upstream still close up, and
// the input stalls only when all 15 stages hold transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module swing_foot_polynomial_trajectory_core
  import swft_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire  [CIDX_W-1:0]        cfg_idx_i,
  input  wire  [CFG_W-1:0]         cfg_wdata_i,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  [PHASE_W-1:0]       phase_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_y_o,
  output logic signed [POS_W-1:0]  pos_z_o,
  output logic signed [VEL_W-1:0]  vel_x_o,
  output logic signed [VEL_W-1:0]  vel_y_o,
  output logic signed [VEL_W-1:0]  vel_z_o
);

  localparam int unsigned NSTEP  = 6;
  localparam int unsigned ST_T   = 1;
  localparam int unsigned NS     = 2 * NSTEP + 3;
  localparam int unsigned ST_OUT = NS - 1;
  localparam int unsigned TW     = FRAC_BITS + 1;
  localparam int unsigned CW     = (TW > PHASE_W) ? TW : PHASE_W;
  localparam int unsigned PPW    = SLOPE_W + TW;
  localparam int unsigned QW     = PPW - FRAC_BITS;
  localparam int unsigned KW     = (QW > TW) ? QW : TW;
  localparam int unsigned MH     = HW + FRAC_BITS + 2;
  localparam int unsigned MG     = GW + FRAC_BITS + 2;

  localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PPW-1:0] P_RND =
    {{(PPW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [MH-1:0] RND_H =
    {{(MH-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [MG-1:0] RND_G =
    {{(MG-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // configuration
  logic signed [POS_W-1:0] start_q [NAX];
  logic signed [POS_W-1:0] fin_q   [NAX];
  logic signed [POS_W-1:0] apex_q;
  logic [SLOPE_W-1:0]      slope_q;
  coef_t                   coef_q  [NAX];

  // pipeline
  logic [NS-1:0]           vld_q;
  logic [NS-1:0]           vld_prev;
  logic [NS-1:0]           en;
  logic [PPW-1:0]          p_q;
  logic                    ge_q;
  logic [TW-1:0]           t_q  [ST_T:2*NSTEP-1];
  logic signed [MH-1:0]    mh_q [NSTEP][NAX];
  logic signed [MG-1:0]    mg_q [NSTEP][NAX];
  logic signed [HW-1:0]    h_q  [NSTEP][NAX];
  logic signed [GW-1:0]    g_q  [NSTEP][NAX];
  logic signed [POS_W-1:0] pos_q [NAX];
  logic signed [VEL_W-1:0] vel_q [NAX];

  logic                    ge_w;
  logic [TW-1:0]           om_w;
  logic [PPW-1:0]          pr_w;
  logic [QW-1:0]           q_w;
  logic                    qge_w;
  logic [TW-1:0]           t_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAX; i++) begin
        start_q[i] <= '0;
        fin_q[i]   <= '0;
      end
      apex_q  <= '0;
      slope_q <= SLOPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_X:     start_q[0] <= cfg_wdata_i[POS_W-1:0];
        REG_START_Y:     start_q[1] <= cfg_wdata_i[POS_W-1:0];
        REG_START_Z:     start_q[2] <= cfg_wdata_i[POS_W-1:0];
        REG_FINAL_X:     fin_q[0]   <= cfg_wdata_i[POS_W-1:0];
        REG_FINAL_Y:     fin_q[1]   <= cfg_wdata_i[POS_W-1:0];
        REG_FINAL_Z:     fin_q[2]   <= cfg_wdata_i[POS_W-1:0];
        REG_APEX_HEIGHT: apex_q     <= cfg_wdata_i[POS_W-1:0];
        REG_PHASE_SLOPE: slope_q    <= cfg_wdata_i[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficients, D = final - start, E = 2*(apex - start) on z and E = D on x, y
  for (genvar ax = 0; ax < NAX; ax++) begin : g_coef
    logic signed [GW-1:0] s_w;
    logic signed [GW-1:0] d_w;
    logic signed [GW-1:0] e_w;
    logic signed [GW-1:0] a3_w;
    logic signed [GW-1:0] a4_w;
    logic signed [GW-1:0] a5_w;
    logic signed [GW-1:0] a6_w;

    assign s_w = GW'(start_q[ax]);
    assign d_w = GW'(fin_q[ax]) - s_w;
    if (ax == AX_Z) begin : g_apex
      assign e_w = (GW'(apex_q) - s_w) <<< 1;
    end else begin : g_flat
      assign e_w = d_w;
    end
    assign a3_w = GW'(32) * e_w - GW'(22) * d_w;
    assign a4_w = GW'(81) * d_w - GW'(96) * e_w;
    assign a5_w = GW'(96) * e_w - GW'(90) * d_w;
    assign a6_w = GW'(32) * d_w - GW'(32) * e_w;

    always_ff @(posedge clk_i) begin
      coef_q[ax].h6 <= HW'(a6_w);
      coef_q[ax].h5 <= HW'(a5_w);
      coef_q[ax].h4 <= HW'(a4_w);
      coef_q[ax].h3 <= HW'(a3_w);
      coef_q[ax].g6 <= GW'(6) * a6_w;
      coef_q[ax].g5 <= GW'(5) * a5_w;
      coef_q[ax].g4 <= GW'(4) * a4_w;
      coef_q[ax].g3 <= GW'(3) * a3_w;
    end
  end

  // stage enables: a stage loads when it or any stage after it has room
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !out_stall_i || !(&vld_q[NS-1:i]);
  end

  assign vld_prev   = {vld_q[NS-2:0], in_valid_i};
  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_prev[i];
        end
      end
    end
  end

  // phase map: q = slope*(1 - phase)
  assign ge_w = CW'(phase_i) >= CW'(T_ONE);
  assign om_w = TW'(CW'(T_ONE) - CW'(phase_i));

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q  <= PPW'(slope_q) * PPW'(om_w);
      ge_q <= ge_w;
    end
  end

  // t = clamp(1 - q, 0, 1)
  assign pr_w  = p_q + P_RND;
  assign q_w   = pr_w[PPW-1:FRAC_BITS];
  assign qge_w = KW'(q_w) >= KW'(T_ONE);
  assign t_d   = ge_q  ? T_ONE :
                 qge_w ? '0    : TW'(KW'(T_ONE) - KW'(q_w));

  always_ff @(posedge clk_i) begin
    if (en[ST_T]) begin
      t_q[ST_T] <= t_d;
    end
  end

  // Horner steps
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    if (k < NSTEP - 1) begin : g_tcarry
      always_ff @(posedge clk_i) begin
        if (en[2+2*k]) begin
          t_q[2+2*k] <= t_q[1+2*k];
        end
        if (en[3+2*k]) begin
          t_q[3+2*k] <= t_q[2+2*k];
        end
      end
    end

    for (genvar ax = 0; ax < NAX; ax++) begin : g_lane
      logic signed [HW-1:0] hin_w;
      logic signed [GW-1:0] gin_w;
      logic [TW-1:0]        tg_w;
      logic signed [HW-1:0] add_h;
      logic signed [GW-1:0] add_g;
      logic signed [MH-1:0] sh_w;
      logic signed [MG-1:0] sg_w;

      if (k == 0) begin : g_first
        assign hin_w = coef_q[ax].h6;
        assign gin_w = coef_q[ax].g6;
      end else begin : g_next
        assign hin_w = h_q[k-1][ax];
        assign gin_w = g_q[k-1][ax];
      end

      // velocity has one multiply fewer; t = 1 leaves it unchanged
      if (k == NSTEP - 1) begin : g_tg_one
        assign tg_w = T_ONE;
      end else begin : g_tg_t
        assign tg_w = t_q[1+2*k];
      end

      if (k == 0) begin : g_add5
        assign add_h = coef_q[ax].h5;
        assign add_g = coef_q[ax].g5;
      end else if (k == 1) begin : g_add4
        assign add_h = coef_q[ax].h4;
        assign add_g = coef_q[ax].g4;
      end else if (k == 2) begin : g_add3
        assign add_h = coef_q[ax].h3;
        assign add_g = coef_q[ax].g3;
      end else begin : g_add0
        assign add_h = '0;
        assign add_g = '0;
      end

      assign sh_w = mh_q[k][ax] + RND_H;
      assign sg_w = mg_q[k][ax] + RND_G;

      always_ff @(posedge clk_i) begin
        if (en[2+2*k]) begin
          mh_q[k][ax] <= hin_w * $signed({1'b0, t_q[1+2*k]});
          mg_q[k][ax] <= gin_w * $signed({1'b0, tg_w});
        end
        if (en[3+2*k]) begin
          h_q[k][ax] <= add_h + $signed(sh_w[FRAC_BITS +: HW]);
          g_q[k][ax] <= add_g + $signed(sg_w[FRAC_BITS +: GW]);
        end
      end
    end
  end

  // output saturation
  for (genvar ax = 0; ax < NAX; ax++) begin : g_out
    logic signed [HW:0] ps_w;

    assign ps_w = (HW+1)'(start_q[ax]) + (HW+1)'(h_q[NSTEP-1][ax]);

    always_ff @(posedge clk_i) begin
      if (en[ST_OUT]) begin
        pos_q[ax] <= sat_pos(ps_w);
        vel_q[ax] <= sat_vel(g_q[NSTEP-1][ax]);
      end
    end
  end

  assign out_valid_o = vld_q[ST_OUT];
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign vel_x_o     = vel_q[0];
  assign vel_y_o     = vel_q[1];
  assign vel_z_o     = vel_q[2];

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transfer did not enter the pipeline");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with a free stage");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_T] |-> (t_q[ST_T] <= T_ONE))
    else $error("trajectory time above one");

  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_OUT] && !out_stall_i && !vld_q[ST_OUT-1]) |=> !vld_q[ST_OUT])
    else $error("result repeated after transfer");

endmodule

`default_nettype wire

### bench/swing_foot_polynomial_trajectory_core_test.sv
// ----------------------------------------------------------------------------
// swing_foot_polynomial_trajectory_core_test
// Self-checking bench for the swing-foot trajectory core. Foot points, apex
// height and phase slope are loaded while the pipeline is empty. Phase samples
// are then streamed with random gaps on the input side and random stalls on
// the output side. Each transfer's position and velocity are predicted in
// fixed point and compared field by field against the core's results.
// ----------------------------------------------------------------------------
`default_nettype none

module swing_foot_polynomial_trajectory_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swft_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam int          LATENCY   = 15;
  localparam int          LIMIT     = 200000;
  localparam int          N_SETS    = 10;
  localparam int          PER_SET   = 140;
  localparam longint      POS_LO    = -(longint'(1) <<< (POS_W - 1));
  localparam longint      POS_HI    = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint      VEL_LO    = -(longint'(1) <<< (VEL_W - 1));
  localparam longint      VEL_HI    = (longint'(1) <<< (VEL_W - 1)) - 1;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vz;
  } foot_ref_t;

  logic                     clk         = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CIDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic [PHASE_W-1:0]       phase_i     = '0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [POS_W-1:0]  pos_x_o, pos_y_o, pos_z_o;
  logic signed [VEL_W-1:0]  vel_x_o, vel_y_o, vel_z_o;

  // shadow of the register file: six points, apex height, slope
  logic signed [POS_W-1:0]  point_reg [0:6];
  logic [SLOPE_W-1:0]       slope_reg;

  // phases around zero, the midpoint and one, points between, and the largest phase
  int                       corner_phase [12] = '{0, 1, 32767, 32768, 32769, 40000,
                                                  49152, 60000, 65535, 65536, 65537,
                                                  131071};

  logic [PHASE_W-1:0]       phase_queue [$];
  foot_ref_t                foot_ref_q [$];
  bit                       calm = 1'b0;
  int                       n_errors = 0;
  int                       cycle = 0;

  swing_foot_polynomial_trajectory_core #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .phase_i     (phase_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .vel_x_o     (vel_x_o),
    .vel_y_o     (vel_y_o),
    .vel_z_o     (vel_z_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- prediction ----------------------------------------------------------

  function automatic longint round_mul(longint a, longint t);
    return (a * t + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic foot_ref_t foot_reference(logic [PHASE_W-1:0] ph);
    longint    one, rem, t, q;
    longint    s, d, e, a3, a4, a5, a6, h, g, p, v;
    foot_ref_t r;
    one = longint'(1) <<< FRAC_BITS;
    rem = one - longint'(ph);
    if (rem <= 0) begin
      t = one;
    end else begin
      q = (longint'(slope_reg) * rem + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      t = one - q;
      if (t < 0) t = 0;
    end
    for (int ax = 0; ax < NAX; ax++) begin
      s  = longint'(point_reg[ax]);
      d  = longint'(point_reg[3 + ax]) - s;
      e  = (ax == AX_Z) ? 2 * (longint'(point_reg[REG_APEX_HEIGHT]) - s) : d;
      a3 = -22 * d + 32 * e;
      a4 = 81 * d - 96 * e;
      a5 = -90 * d + 96 * e;
      a6 = 32 * d - 32 * e;
      h  = a5 + round_mul(a6, t);
      h  = a4 + round_mul(h, t);
      h  = a3 + round_mul(h, t);
      h  = round_mul(round_mul(round_mul(h, t), t), t);
      g  = 5 * a5 + round_mul(6 * a6, t);
      g  = 4 * a4 + round_mul(g, t);
      g  = 3 * a3 + round_mul(g, t);
      g  = round_mul(round_mul(g, t), t);
      p  = clamp(s + h, POS_LO, POS_HI);
      v  = clamp(g, VEL_LO, VEL_HI);
      case (ax)
        0: begin r.px = p[POS_W-1:0]; r.vx = v[VEL_W-1:0]; end
        1: begin r.py = p[POS_W-1:0]; r.vy = v[VEL_W-1:0]; end
        default: begin r.pz = p[POS_W-1:0]; r.vz = v[VEL_W-1:0]; end
      endcase
    end
    return r;
  endfunction

  // ---- configuration and stimulus helpers ---------------------------------

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_PHASE_SLOPE) slope_reg = data;
    else point_reg[idx] = data[POS_W-1:0];
  endtask

  task automatic write_done();
    @(posedge clk);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_point();
    logic [CFG_W-1:0] data;
    data = CFG_W'($urandom);
    case ($urandom_range(4))
      0: data[POS_W-1:0] = {1'b1, {(POS_W-1){1'b0}}};
      1: data[POS_W-1:0] = {1'b0, {(POS_W-1){1'b1}}};
      2: data[POS_W-1:0] = POS_W'(int'($urandom_range(65536)) - 32768);
      default: ;
    endcase
    return data;
  endfunction

  function automatic logic [CFG_W-1:0] pick_slope();
    case ($urandom_range(6))
      0: return '0;
      1: return CFG_W'(65536);
      2: return CFG_W'(4194304);
      3: return '1;
      4: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(4194304, 65536));
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] pick_phase();
    longint lo;
    lo = (slope_reg == 0) ? 0 : 65536 - (longint'(1) <<< 32) / longint'(slope_reg);
    if (lo < 0) lo = 0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return PHASE_W'($urandom_range(65536, int'(lo)));
      5, 6:          return PHASE_W'($urandom_range(131071));
      7:             return PHASE_W'(65528 + $urandom_range(16));
      default:       return PHASE_W'($urandom_range(65536));
    endcase
  endfunction

  // wait until every queued phase has transferred and every result is back
  task automatic drain();
    do @(posedge clk);
    while (phase_queue.size() != 0 || in_valid_i || foot_ref_q.size() != 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what);
    n_errors++;
    $display("ERROR cycle %0d: %s", cycle, what);
  endtask

  task automatic check_field(string nm, longint got, longint want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", nm, got, want));
  endtask

  // ---- driver ----------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) foot_ref_q.push_back(foot_reference(phase_i));
      if (!in_valid_i || !in_stall_o) begin
        if (phase_queue.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
          in_valid_i <= 1'b1;
          phase_i    <= phase_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ---------------------------------------------------------------

  always @(posedge clk) begin : monitor
    foot_ref_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (foot_ref_q.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          want = foot_ref_q.pop_front();
          check_field("pos_x", pos_x_o, want.px);
          check_field("pos_y", pos_y_o, want.py);
          check_field("pos_z", pos_z_o, want.pz);
          check_field("vel_x", vel_x_o, want.vx);
          check_field("vel_y", vel_y_o, want.vy);
          check_field("vel_z", vel_z_o, want.vz);
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("swing_foot_polynomial_trajectory_core: mismatch");
      $finish;
    end
  end

  // ---- sequence --------------------------------------------------------------

  initial begin
    for (int i = 0; i < 7; i++) point_reg[i] = '0;
    slope_reg = SLOPE_RST;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;

    // reset defaults: everything at the origin
    phase_queue.push_back(PHASE_W'(0));
    phase_queue.push_back(PHASE_W'(65536));
    drain();

    // opposite corners, apex at the top, slope 2.0
    write_reg(REG_START_X, CFG_W'(21'h100000));
    write_reg(REG_START_Y, CFG_W'(21'h0FFFFF));
    write_reg(REG_START_Z, '0);
    write_reg(REG_FINAL_X, CFG_W'(21'h0FFFFF));
    write_reg(REG_FINAL_Y, {2'b11, 21'h100000});
    write_reg(REG_FINAL_Z, CFG_W'(20000));
    write_reg(REG_APEX_HEIGHT, CFG_W'(21'h0FFFFF));
    write_reg(REG_PHASE_SLOPE, CFG_W'(131072));
    write_done();
    foreach (corner_phase[i]) phase_queue.push_back(PHASE_W'(corner_phase[i]));
    drain();

    // zero slope holds t at one
    write_reg(REG_PHASE_SLOPE, '0);
    write_done();
    phase_queue.push_back(PHASE_W'(0));
    phase_queue.push_back(PHASE_W'(70000));
    drain();

    // full-scale slope pins t at zero below one
    write_reg(REG_PHASE_SLOPE, '1);
    write_done();
    phase_queue.push_back(PHASE_W'(65535));
    phase_queue.push_back(PHASE_W'(65536));
    phase_queue.push_back(PHASE_W'(0));
    drain();

    for (int k = 0; k < N_SETS; k++) begin
      calm = (k == 4);
      for (int i = 0; i < 7; i++) begin
        case (k)
          1: write_reg(cfg_reg_e'(i), CFG_W'(21'h100000));
          2: write_reg(cfg_reg_e'(i), CFG_W'(21'h0FFFFF));
          default: write_reg(cfg_reg_e'(i), pick_point());
        endcase
      end
      case (k)
        1: write_reg(REG_PHASE_SLOPE, CFG_W'(4194304));
        2: write_reg(REG_PHASE_SLOPE, CFG_W'(65536));
        default: write_reg(REG_PHASE_SLOPE, pick_slope());
      endcase
      write_done();
      for (int n = 0; n < PER_SET; n++) phase_queue.push_back(pick_phase());
      drain();
    end

    if (n_errors == 0) begin
      $display("swing_foot_polynomial_trajectory_core: match");
    end else begin
      $display("swing_foot_polynomial_trajectory_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

### swing_foot_polynomial_trajectory_core.f
rtl/swft_pkg.sv
rtl/swing_foot_polynomial_trajectory_core.sv
bench/swing_foot_polynomial_trajectory_core_test.sv
